### rtl/fos_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fos_pkg
// Shared types, constants and constant tables for the fuzzy obstacle
// steering unit.
// ============================================================================
package fos_pkg;

    localparam int GRID_POINTS = 21;
    localparam int GRADE_BITS  = 9;
    localparam int GRADE_ONE   = 1 << (GRADE_BITS - 1);

    localparam int DIST_MAX  = 100;
    localparam int AXIS_LO   = -240;
    localparam int AXIS_SPAN = 400;
    localparam int SCORE_LO  = -240;
    localparam int SCORE_HI  = 160;

    localparam int CM_W    = 9;
    localparam int DIST_W  = 7;
    localparam int SCORE_W = 9;
    localparam int QUO_W   = 8;
    localparam int NUM_W   = $clog2(GRID_POINTS * 240 * GRADE_ONE) + 2;
    localparam int DEN_W   = $clog2(GRID_POINTS * GRADE_ONE + 1);
    localparam int DIV_W   = NUM_W;
    localparam int NGRP    = (GRID_POINTS + 3) / 4;

    localparam int NSET = 4;
    // input fuzzy sets
    localparam int IN_VCLOSE = 0;
    localparam int IN_CLOSE  = 1;
    localparam int IN_MEDIUM = 2;
    localparam int IN_FAR    = 3;
    // output fuzzy sets
    localparam int OUT_LEFT  = 0;
    localparam int OUT_STR   = 1;
    localparam int OUT_RIGHT = 2;
    localparam int OUT_BACK  = 3;

    typedef enum logic [1:0] {
        REG_BACK_LIMIT  = 2'd0,
        REG_LEFT_LIMIT  = 2'd1,
        REG_RIGHT_LIMIT = 2'd2,
        REG_NONE        = 2'd3
    } fos_reg_t;

    typedef enum logic [1:0] {
        DIR_BACK     = 2'd0,
        DIR_LEFT     = 2'd1,
        DIR_RIGHT    = 2'd2,
        DIR_STRAIGHT = 2'd3
    } fos_dir_t;

    typedef struct packed {
        logic [CM_W-1:0] front_cm;
        logic [CM_W-1:0] right_cm;
        logic [CM_W-1:0] left_cm;
    } fos_in_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] steer_score;
        logic [1:0]                direction;
    } fos_out_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } fos_side_t;

    typedef logic [GRADE_BITS-1:0]     grade_t;
    typedef grade_t                    dist_lut_t [0:DIST_MAX];
    typedef grade_t                    grid_lut_t [0:GRID_POINTS-1];
    typedef logic signed [SCORE_W-1:0] grid_x_t   [0:GRID_POINTS-1];

    function automatic dist_lut_t build_dist_lut(input int set);
        dist_lut_t lut;
        int        g;
        for (int d = 0; d <= DIST_MAX; d++) begin
            g = 0;
            case (set)
                IN_VCLOSE:
                begin
                    if (d == 0) g = GRADE_ONE;
                    else if (d < 20) g = ((20 - d) * GRADE_ONE + 10) / 20;
                end
                IN_CLOSE:
                begin
                    if (d == 30) g = GRADE_ONE;
                    else if (d > 10 && d < 30) g = ((d - 10) * GRADE_ONE + 10) / 20;
                    else if (d > 30 && d < 50) g = ((50 - d) * GRADE_ONE + 10) / 20;
                end
                IN_MEDIUM:
                begin
                    if (d == 60) g = GRADE_ONE;
                    else if (d > 40 && d < 60) g = ((d - 40) * GRADE_ONE + 10) / 20;
                    else if (d > 60 && d < 80) g = ((80 - d) * GRADE_ONE + 10) / 20;
                end
                default:
                begin
                    if (d == 100) g = GRADE_ONE;
                    else if (d > 70) g = ((d - 70) * GRADE_ONE + 15) / 30;
                end
            endcase
            lut[d] = grade_t'(g);
        end
        return lut;
    endfunction

    function automatic int grid_x_val(input int i);
        return AXIS_LO + (i * AXIS_SPAN + (GRID_POINTS - 1) / 2) / (GRID_POINTS - 1);
    endfunction

    function automatic grid_x_t build_grid_x();
        grid_x_t t;
        for (int i = 0; i < GRID_POINTS; i++)
            t[i] = SCORE_W'(grid_x_val(i));
        return t;
    endfunction

    function automatic grid_lut_t build_grid_lut(input int set);
        grid_lut_t t;
        int        x;
        int        g;
        for (int i = 0; i < GRID_POINTS; i++) begin
            x = grid_x_val(i);
            g = 0;
            case (set)
                OUT_LEFT:
                begin
                    if (x == -160) g = GRADE_ONE;
                    else if (x > -160 && x < 0) g = ((0 - x) * GRADE_ONE + 80) / 160;
                end
                OUT_STR:
                begin
                    if (x == 0) g = GRADE_ONE;
                    else if (x > -80 && x < 0) g = ((x + 80) * GRADE_ONE + 40) / 80;
                    else if (x > 0 && x < 80) g = ((80 - x) * GRADE_ONE + 40) / 80;
                end
                OUT_RIGHT:
                begin
                    if (x == 160) g = GRADE_ONE;
                    else if (x > 0 && x < 160) g = (x * GRADE_ONE + 80) / 160;
                end
                default:
                begin
                    if (x == -240) g = GRADE_ONE;
                    else if (x > -240 && x < -160) g = ((-160 - x) * GRADE_ONE + 40) / 80;
                end
            endcase
            t[i] = grade_t'(g);
        end
        return t;
    endfunction

    localparam dist_lut_t LUT_VCLOSE = build_dist_lut(IN_VCLOSE);
    localparam dist_lut_t LUT_CLOSE  = build_dist_lut(IN_CLOSE);
    localparam dist_lut_t LUT_MEDIUM = build_dist_lut(IN_MEDIUM);
    localparam dist_lut_t LUT_FAR    = build_dist_lut(IN_FAR);

    localparam grid_x_t   GRID_X     = build_grid_x();
    localparam grid_lut_t GRID_LEFT  = build_grid_lut(OUT_LEFT);
    localparam grid_lut_t GRID_STR   = build_grid_lut(OUT_STR);
    localparam grid_lut_t GRID_RIGHT = build_grid_lut(OUT_RIGHT);
    localparam grid_lut_t GRID_BACK  = build_grid_lut(OUT_BACK);

endpackage

### rtl/fos_div.sv
`timescale 1ns / 1ps
// ============================================================================
// fos_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ============================================================================
module fos_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [fos_pkg::DIV_W-1:0] dividend,
    input  logic [fos_pkg::DEN_W-1:0] divisor,
    input  fos_pkg::fos_side_t        in_side,
    output logic                      out_valid,
    output logic [fos_pkg::QUO_W-1:0] quotient,
    output fos_pkg::fos_side_t        out_side
);
    import fos_pkg::*;

    logic              v_reg    [0:QUO_W];
    logic [DIV_W-1:0]  rem_reg  [0:QUO_W];
    logic [DEN_W-1:0]  den_reg  [0:QUO_W];
    logic [QUO_W-1:0]  q_reg    [0:QUO_W];
    fos_side_t         side_reg [0:QUO_W];

    always_comb
    begin
        v_reg[0]    = in_valid;
        rem_reg[0]  = dividend;
        den_reg[0]  = divisor;
        q_reg[0]    = '0;
        side_reg[0] = in_side;
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        localparam int SH = QUO_W - 1 - k;
        logic [DIV_W-1:0] trial;
        logic             take;
        logic [QUO_W-1:0] q_next;
        logic [DIV_W-1:0] rem_next;

        always_comb
        begin
            trial    = DIV_W'(den_reg[k]) << SH;
            take     = rem_reg[k] >= trial;
            rem_next = take ? rem_reg[k] - trial : rem_reg[k];
            q_next   = q_reg[k];
            q_next[SH] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_reg[k];
                q_reg[k+1]    <= q_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign quotient  = q_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

### rtl/fuzzy_obstacle_steering_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// fuzzy_obstacle_steering_unit
// Mamdani fuzzy steering: fuzzify three distances, min/max rules, sampled
// centroid and a direction class against three limit registers.
// ============================================================================
//  channel   signals                          beat
//  in        in_valid / in_ready / in_data    front, right, left distances
//  out       out_valid / out_ready / out_data score and direction
//  cfg       cfg_wen / cfg_idx / cfg_wdata    one limit register write
//
// One beat per cycle unless stalled; a beat passes the fuzzify to rounding
// stages, the one-bit-per-stage divider and the output register. All stages
// move together when the output register is empty or taken; a stall freezes
// the whole pipe. Reset clears valid bits and loads the default limits.
// ============================================================================
module fuzzy_obstacle_steering_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fos_pkg::fos_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output fos_pkg::fos_out_t           out_data,
    input  logic                        cfg_wen,
    input  logic [1:0]                  cfg_idx,
    input  logic [fos_pkg::SCORE_W-1:0] cfg_wdata
);
    import fos_pkg::*;

    logic en;
    logic signed [SCORE_W-1:0] back_lim_reg, left_lim_reg, right_lim_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    grade_t f_reg [0:NSET-1];
    grade_t rc_reg, rf_reg, lc_reg, lf_reg;
    grade_t p_reg [0:NSET-1];
    grade_t g_reg [0:GRID_POINTS-1];

    logic signed [NUM_W-1:0] pn_reg [0:NGRP-1];
    logic [DEN_W-1:0]        pd_reg [0:NGRP-1];
    logic signed [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DIV_W-1:0]        dvd_reg;
    logic [DEN_W-1:0]        dvs_reg;
    fos_side_t               side_reg;

    logic                 dv_valid;
    logic [QUO_W-1:0]     dv_q;
    fos_side_t            dv_side;

    logic                 out_valid_reg;
    fos_out_t             out_data_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            back_lim_reg  <= -9'sd176;
            left_lim_reg  <= -9'sd32;
            right_lim_reg <= 9'sd32;
        end
        else if (cfg_wen)
        begin
            case (fos_reg_t'(cfg_idx))
                REG_BACK_LIMIT:  back_lim_reg  <= cfg_wdata;
                REG_LEFT_LIMIT:  left_lim_reg  <= cfg_wdata;
                REG_RIGHT_LIMIT: right_lim_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // stage 1: clamp and fuzzify
    logic [DIST_W-1:0] fd, rd, ld;

    function automatic logic [DIST_W-1:0] clamp_cm(input logic [CM_W-1:0] v);
        return (v > CM_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : v[DIST_W-1:0];
    endfunction

    always_comb
    begin
        fd = clamp_cm(in_data.front_cm);
        rd = clamp_cm(in_data.right_cm);
        ld = clamp_cm(in_data.left_cm);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg[IN_VCLOSE] <= LUT_VCLOSE[fd];
            f_reg[IN_CLOSE]  <= LUT_CLOSE[fd];
            f_reg[IN_MEDIUM] <= LUT_MEDIUM[fd];
            f_reg[IN_FAR]    <= LUT_FAR[fd];
            rc_reg           <= LUT_CLOSE[rd];
            rf_reg           <= LUT_FAR[rd];
            lc_reg           <= LUT_CLOSE[ld];
            lf_reg           <= LUT_FAR[ld];
        end
    end

    // stage 2: rule strengths
    function automatic grade_t gmin(input grade_t a, input grade_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic grade_t gmax(input grade_t a, input grade_t b);
        return (a > b) ? a : b;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[OUT_STR]   <= gmax(f_reg[IN_FAR], f_reg[IN_MEDIUM]);
            p_reg[OUT_LEFT]  <= gmax(rc_reg, gmin(f_reg[IN_CLOSE], lf_reg));
            p_reg[OUT_RIGHT] <= gmax(lc_reg, gmin(f_reg[IN_CLOSE], rf_reg));
            p_reg[OUT_BACK]  <= f_reg[IN_VCLOSE];
        end
    end

    // stage 3: aggregate at each grid point
    grade_t g_next [0:GRID_POINTS-1];

    always_comb
    begin
        for (int i = 0; i < GRID_POINTS; i++)
            g_next[i] = gmax(gmax(gmin(p_reg[OUT_LEFT], GRID_LEFT[i]),
                                  gmin(p_reg[OUT_STR], GRID_STR[i])),
                             gmax(gmin(p_reg[OUT_RIGHT], GRID_RIGHT[i]),
                                  gmin(p_reg[OUT_BACK], GRID_BACK[i])));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            g_reg <= g_next;
    end

    // stage 4: weighted partial sums, four points per group
    logic signed [NUM_W-1:0] pn_next [0:NGRP-1];
    logic [DEN_W-1:0]        pd_next [0:NGRP-1];

    always_comb
    begin
        for (int j = 0; j < NGRP; j++) begin
            pn_next[j] = '0;
            pd_next[j] = '0;
            for (int k = 0; k < 4; k++) begin
                if (j * 4 + k < GRID_POINTS)
                begin
                    pn_next[j] = pn_next[j]
                        + NUM_W'(GRID_X[j*4+k]) * NUM_W'($signed({1'b0, g_reg[j*4+k]}));
                    pd_next[j] = pd_next[j] + DEN_W'(g_reg[j*4+k]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pn_reg <= pn_next;
            pd_reg <= pd_next;
        end
    end

    // stage 5: totals
    logic signed [NUM_W-1:0] num_next;
    logic [DEN_W-1:0]        den_next;

    always_comb
    begin
        num_next = '0;
        den_next = '0;
        for (int j = 0; j < NGRP; j++) begin
            num_next = num_next + pn_reg[j];
            den_next = den_next + pd_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // stage 6: magnitude plus half divisor for round half away from zero
    logic [DIV_W-1:0] mag;

    always_comb
    begin
        mag = num_reg[NUM_W-1] ? DIV_W'(-num_reg) : DIV_W'(num_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg       <= mag + DIV_W'(den_reg >> 1);
            dvs_reg       <= den_reg;
            side_reg.neg  <= num_reg[NUM_W-1];
            side_reg.zero <= (den_reg == '0);
        end
    end

    fos_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .dividend  (dvd_reg),
        .divisor   (dvs_reg),
        .in_side   (side_reg),
        .out_valid (dv_valid),
        .quotient  (dv_q),
        .out_side  (dv_side)
    );

    // output stage: sign, clamp, classify
    logic signed [SCORE_W:0]   s_wide;
    logic signed [SCORE_W-1:0] score;
    fos_dir_t                  dir;

    always_comb
    begin
        s_wide = dv_side.neg ? -$signed({2'b00, dv_q}) : $signed({2'b00, dv_q});
        if (dv_side.zero)
            score = '0;
        else if (s_wide < (SCORE_W+1)'(SCORE_LO))
            score = SCORE_W'(SCORE_LO);
        else if (s_wide > (SCORE_W+1)'(SCORE_HI))
            score = SCORE_W'(SCORE_HI);
        else
            score = s_wide[SCORE_W-1:0];

        if (score < back_lim_reg)
            dir = DIR_BACK;
        else if (score < left_lim_reg)
            dir = DIR_LEFT;
        else if (score > right_lim_reg)
            dir = DIR_RIGHT;
        else
            dir = DIR_STRAIGHT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.steer_score <= score;
            out_data_reg.direction   <= dir;
        end
    end

endmodule

### dv/fuzzy_obstacle_steering_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// fuzzy_obstacle_steering_unit_test
// Self-checking bench for the fuzzy steering unit. Distance beats are driven
// from a queue with random idling on both sides, scores and directions are
// predicted per beat and compared in order, and the limit registers are
// rewritten between phases while the pipe is empty.
// ============================================================================
module fuzzy_obstacle_steering_unit_test;
    import fos_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    fos_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    fos_out_t out_data;
    logic     cfg_wen = 1'b0;
    logic [1:0] cfg_idx = REG_NONE;
    logic [SCORE_W-1:0] cfg_wdata = '0;

    fuzzy_obstacle_steering_unit DUT (.*);

    always #1 clk = ~clk;

    fos_in_t  pending_beats[$];
    fos_out_t expected_steer[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int stall_count = 0;
    int beats_in = 0;
    int beats_out = 0;
    int lim_back = -176;
    int lim_left = -32;
    int lim_right = 32;
    logic in_taken = 1'b0;

    function automatic int tri_grade(int x, int a, int b, int c);
        int one;
        one = 1 << (GRADE_BITS - 1);
        if (x == b) return one;
        if (x <= a || x >= c) return 0;
        if (x < b) return ((x - a) * one + (b - a) / 2) / (b - a);
        return ((c - x) * one + (c - b) / 2) / (c - b);
    endfunction

    function automatic int imin(int a, int b);
        return a < b ? a : b;
    endfunction

    function automatic int imax(int a, int b);
        return a > b ? a : b;
    endfunction

    function automatic fos_out_t steer_predict(fos_in_t d);
        int f[4], r[4], l[4];
        int raw[3];
        int cm, x, g, num, den, score;
        int s_left, s_str, s_right, s_back;
        fos_out_t res;
        raw[0] = int'(d.front_cm);
        raw[1] = int'(d.right_cm);
        raw[2] = int'(d.left_cm);
        for (int k = 0; k < 3; k++) begin
            cm = raw[k] > 100 ? 100 : raw[k];
            if (k == 0)
            begin
                f[0] = tri_grade(cm, 0, 0, 20);   f[1] = tri_grade(cm, 10, 30, 50);
                f[2] = tri_grade(cm, 40, 60, 80); f[3] = tri_grade(cm, 70, 100, 100);
            end
            else if (k == 1)
            begin
                r[0] = tri_grade(cm, 0, 0, 20);   r[1] = tri_grade(cm, 10, 30, 50);
                r[2] = tri_grade(cm, 40, 60, 80); r[3] = tri_grade(cm, 70, 100, 100);
            end
            else
            begin
                l[0] = tri_grade(cm, 0, 0, 20);   l[1] = tri_grade(cm, 10, 30, 50);
                l[2] = tri_grade(cm, 40, 60, 80); l[3] = tri_grade(cm, 70, 100, 100);
            end
        end
        s_str = imax(f[3], f[2]);
        s_left = imax(r[1], imin(f[1], l[3]));
        s_right = imax(l[1], imin(f[1], r[3]));
        s_back = f[0];
        num = 0;
        den = 0;
        for (int i = 0; i < GRID_POINTS; i++) begin
            x = -240 + (i * 400 + (GRID_POINTS - 1) / 2) / (GRID_POINTS - 1);
            g = 0;
            g = imax(g, imin(s_left, tri_grade(x, -160, -160, 0)));
            g = imax(g, imin(s_str, tri_grade(x, -80, 0, 80)));
            g = imax(g, imin(s_right, tri_grade(x, 0, 160, 160)));
            g = imax(g, imin(s_back, tri_grade(x, -240, -240, -160)));
            num += x * g;
            den += g;
        end
        score = 0;
        if (den != 0)
        begin
            if (num >= 0) score = (num + den / 2) / den;
            else score = -((-num + den / 2) / den);
            if (score < -240) score = -240;
            if (score > 160) score = 160;
        end
        res.steer_score = SCORE_W'(score);
        if (score < lim_back) res.direction = DIR_BACK;
        else if (score < lim_left) res.direction = DIR_LEFT;
        else if (score > lim_right) res.direction = DIR_RIGHT;
        else res.direction = DIR_STRAIGHT;
        return res;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_beats.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_steer.push_back(steer_predict(in_data));
                beats_in++;
            end
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (expected_steer.size() == 0)
                begin
                    $error("unexpected beat: steer_score %0d direction %0d",
                           out_data.steer_score, out_data.direction);
                    errors++;
                end
                else
                begin
                    fos_out_t want;
                    want = expected_steer.pop_front();
                    if (out_data.steer_score !== want.steer_score)
                    begin
                        $error("steer_score expected %0d actual %0d",
                               want.steer_score, out_data.steer_score);
                        errors++;
                    end
                    if (out_data.direction !== want.direction)
                    begin
                        $error("direction expected %0d actual %0d",
                               want.direction, out_data.direction);
                        errors++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count > 20000)
            begin
                $display("fuzzy_obstacle_steering_unit_test failed");
                $finish;
            end
        end
    end

    task automatic write_limit(fos_reg_t idx, int value);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= SCORE_W'(value);
        @(negedge clk);
        cfg_wen <= 1'b0;
        cfg_idx <= REG_NONE;
        case (idx)
            REG_BACK_LIMIT: lim_back = value;
            REG_LEFT_LIMIT: lim_left = value;
            default: lim_right = value;
        endcase
    endtask

    task automatic drain_pipe();
        while (pending_beats.size() > 0 || in_valid || expected_steer.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic fos_in_t rand_beat();
        fos_in_t d;
        int mode;
        mode = $urandom_range(9);
        if (mode < 7)
        begin
            d.front_cm = CM_W'($urandom_range(110));
            d.right_cm = CM_W'($urandom_range(110));
            d.left_cm = CM_W'($urandom_range(110));
        end
        else
        begin
            d.front_cm = CM_W'($urandom);
            d.right_cm = CM_W'($urandom);
            d.left_cm = CM_W'($urandom);
        end
        return d;
    endfunction

    initial
    begin
        int pts[14] = '{0, 1, 10, 19, 20, 30, 40, 50, 60, 70, 80, 99, 100, 101};
        fos_in_t d;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 45;
        for (int i = 0; i < 14; i++) begin
            d.front_cm = CM_W'(pts[i]);
            d.right_cm = CM_W'(pts[(i + 5) % 14]);
            d.left_cm = CM_W'(pts[(i + 9) % 14]);
            pending_beats.push_back(d);
        end
        d = '{9'd511, 9'd511, 9'd511}; pending_beats.push_back(d);
        d = '{9'd0, 9'd0, 9'd0};       pending_beats.push_back(d);
        d = '{9'd30, 9'd100, 9'd30};   pending_beats.push_back(d);
        d = '{9'd30, 9'd30, 9'd100};   pending_beats.push_back(d);
        d = '{9'd30, 9'd100, 9'd100};  pending_beats.push_back(d);
        d = '{9'd100, 9'd30, 9'd511};  pending_beats.push_back(d);
        d = '{9'd5, 9'd256, 9'd255};   pending_beats.push_back(d);
        drain_pipe();

        for (int i = 0; i < 200; i++) pending_beats.push_back(rand_beat());
        drain_pipe();

        write_limit(REG_BACK_LIMIT, -240);
        write_limit(REG_LEFT_LIMIT, 160);
        write_limit(REG_RIGHT_LIMIT, -240);
        send_idle_pct = 45;
        recv_idle_pct = 26;
        for (int i = 0; i < 200; i++) pending_beats.push_back(rand_beat());
        drain_pipe();

        write_limit(REG_BACK_LIMIT, 160);
        write_limit(REG_LEFT_LIMIT, -240);
        write_limit(REG_RIGHT_LIMIT, 160);
        for (int i = 0; i < 60; i++) pending_beats.push_back(rand_beat());
        drain_pipe();

        write_limit(REG_BACK_LIMIT, $signed($urandom_range(400)) - 240);
        write_limit(REG_LEFT_LIMIT, $signed($urandom_range(400)) - 240);
        write_limit(REG_RIGHT_LIMIT, $signed($urandom_range(400)) - 240);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_cycles = 80;
        for (int i = 0; i < 140; i++) pending_beats.push_back(rand_beat());
        drain_pipe();

        $display("steering run: %0d distance beats in, %0d score beats out,", beats_in,
                 beats_out);
        $display("four limit settings incl. extremes, idle mixes and a long output stall");
        if (errors == 0)
            $display("fuzzy_obstacle_steering_unit_test passed");
        else
            $display("fuzzy_obstacle_steering_unit_test failed");
        $finish;
    end
endmodule
